/* src/calendar_date_adder_macros.svh */
// assertion macros for the checker file
`ifndef CALENDAR_DATE_ADDER_MACROS_SVH
`define CALENDAR_DATE_ADDER_MACROS_SVH

// same-cycle implication, held off during reset
`define CDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cda_pkg.sv */
// types, constants and helpers for the calendar date adder
package cda_pkg;

  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned AMT_W   = 12;
  localparam int unsigned REM_W   = 13;
  localparam int unsigned Q12_W   = 9;
  localparam int unsigned R25_W   = 6;

  localparam int unsigned YEAR_CAP = 9999;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam int unsigned      RESET_YEAR  = 2012;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd7;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd12;

  // reciprocal multipliers: floor(x / 12) for x < 2^13, floor(y / 25) for y < 2^16,
  // both under-estimate by at most one
  localparam logic [10:0] DIV12_MUL   = 11'd1365;
  localparam int unsigned DIV12_SHIFT = 14;
  localparam logic [11:0] DIV25_MUL   = 12'd2621;
  localparam int unsigned DIV25_SHIFT = 16;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

  typedef enum logic [1:0] {
    REQ_LOAD       = 2'd0,
    REQ_ADD_DAYS   = 2'd1,
    REQ_ADD_MONTHS = 2'd2,
    REQ_ADD_YEARS  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD_YEARS,
    ST_MON_MUL,
    ST_MON_APPLY,
    ST_DAYS_FIRST,
    ST_DAYS_WALK,
    ST_LEAP_MUL,
    ST_LEAP_CHK,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_LOAD,
    DP_ADD_YEARS,
    DP_MON_MUL,
    DP_MON_APPLY,
    DP_DAYS_FIRST,
    DP_DAYS_WALK,
    DP_LEAP_MUL,
    DP_LEAP_CHK,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cda_cmd_t;

  typedef struct packed {
    logic first_fits;
    logic walk_stop;
    logic month_wrap;
  } cda_sts_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                input logic leap);
    logic [3:0] idx;
    idx = (month >= MONTH_JAN && month <= MONTH_DEC) ? month - 4'd1 : 4'd0;
    if (month == MONTH_FEB && leap) begin
      return FEB_LEAP_LEN;
    end
    return MONTH_LEN[idx];
  endfunction

endpackage

/* src/calendar_date_adder.sv */
// top level: gregorian calendar date register with load and add requests
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  req_type_i, load_year_i, load_month_i,
//                                                load_day_i, amount_i
//   out      output     out_valid_o / out_ready_i cur_year_o, cur_month_o, cur_day_o
//
// one transaction at a time; a result is held in an output register so the next
// transaction is taken while it waits.
// load and add years: the date step, then the leap refresh and the finish step; add months:
// the /12 multiply and apply, then the same; add days: a first step, one walk step per month
// walked and a leap refresh (via the /25 multiplier) per year boundary crossed, then finish.
// reset gives 2012-07-12 in the date register, not the output register; no clearing pass; out_valid_o low.
// a stalled output only holds a finished transaction at its last step.
module calendar_date_adder #(
  parameter int YEAR_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [YEAR_BITS-1:0]        load_year_i,
  input  logic [cda_pkg::MONTH_W-1:0] load_month_i,
  input  logic [cda_pkg::DAY_W-1:0]   load_day_i,
  input  logic [cda_pkg::AMT_W-1:0]   amount_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [YEAR_BITS-1:0]        cur_year_o,
  output logic [cda_pkg::MONTH_W-1:0] cur_month_o,
  output logic [cda_pkg::DAY_W-1:0]   cur_day_o
);
  import cda_pkg::*;

  cda_cmd_t cmd;
  cda_sts_t sts;

  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cda_dp #(
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .load_year_i  (load_year_i),
    .load_month_i (load_month_i),
    .load_day_i   (load_day_i),
    .amount_i     (amount_i),
    .cur_year_o   (cur_year_o),
    .cur_month_o  (cur_month_o),
    .cur_day_o    (cur_day_o)
  );

endmodule

/* src/cda_dp.sv */
// datapath: date registers, leap flag, month divider and day walk arithmetic
module cda_dp #(
  parameter int YEAR_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cda_pkg::cda_cmd_t             cmd_i,
  output cda_pkg::cda_sts_t             sts_o,
  input  logic [YEAR_BITS-1:0]          load_year_i,
  input  logic [cda_pkg::MONTH_W-1:0]   load_month_i,
  input  logic [cda_pkg::DAY_W-1:0]     load_day_i,
  input  logic [cda_pkg::AMT_W-1:0]     amount_i,
  output logic [YEAR_BITS-1:0]          cur_year_o,
  output logic [cda_pkg::MONTH_W-1:0]   cur_month_o,
  output logic [cda_pkg::DAY_W-1:0]     cur_day_o
);
  import cda_pkg::*;

  localparam int unsigned YEAR_FULL = (1 << YEAR_BITS) - 1;
  localparam int unsigned YEAR_LIM  = (YEAR_FULL < YEAR_CAP) ? YEAR_FULL : YEAR_CAP;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = YEAR_BITS'(YEAR_LIM);
  localparam int unsigned Q25_W = YEAR_BITS - 4;
  localparam int unsigned P25_W = YEAR_BITS + 12;
  localparam int unsigned P12_W = REM_W + 11;

  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [MONTH_W-1:0]   month_q, month_d;
  logic [DAY_W-1:0]     day_q, day_d;
  logic                 leap_q, leap_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [Q12_W-1:0]     q12_q, q12_d;
  logic [Q25_W-1:0]     q25_q, q25_d;

  logic [YEAR_BITS-1:0] ld_year_q, ld_year_d;
  logic [MONTH_W-1:0]   ld_month_q, ld_month_d;
  logic [DAY_W-1:0]     ld_day_q, ld_day_d;
  logic [AMT_W-1:0]     amt_q, amt_d;

  logic [YEAR_BITS-1:0] out_year_q, out_year_d;
  logic [MONTH_W-1:0]   out_month_q, out_month_d;
  logic [DAY_W-1:0]     out_day_q, out_day_d;

  logic [DAY_W-1:0]     md;
  logic                 month_wrap;
  logic [MONTH_W-1:0]   month_nx;
  logic [YEAR_BITS-1:0] year_nx;
  logic                 first_fits;
  logic [REM_W-1:0]     rem_first;
  logic                 walk_stop;
  logic [REM_W-1:0]     total;
  logic [P12_W-1:0]     prod12;
  logic [REM_W-1:0]     r12_raw;
  logic [MONTH_W-1:0]   r12;
  logic [Q12_W:0]       q12_fix;
  logic [P25_W-1:0]     prod25;
  logic [YEAR_BITS-1:0] r25_raw;
  logic [R25_W-1:0]     r25;
  logic                 leap_nx;
  logic [MONTH_W-1:0]   load_month_fix;

  function automatic logic [YEAR_BITS-1:0] sat_year(input logic [YEAR_BITS:0] v);
    if (v > {1'b0, YEAR_MAX}) begin
      return YEAR_MAX;
    end
    return v[YEAR_BITS-1:0];
  endfunction

  // month length, next month and year, and the first-step and walk-stop tests of a day addition
  always_comb begin
    md         = days_in(month_q, leap_q);
    month_wrap = (month_q >= MONTH_DEC);
    month_nx   = month_wrap ? MONTH_JAN : month_q + 4'd1;
    year_nx    = month_wrap ? sat_year({1'b0, year_q} + (YEAR_BITS+1)'(1)) : year_q;
    first_fits = (day_q <= md) && (AMT_W'(md - day_q) >= amt_q);
    rem_first  = REM_W'(amt_q) + REM_W'(day_q) - REM_W'(md) - REM_W'(1);
    walk_stop  = (rem_q < REM_W'(md));
  end

  // month addition: (month - 1 + amount) split by twelve
  always_comb begin
    total   = REM_W'(month_q) - REM_W'(1) + REM_W'(amt_q);
    prod12  = P12_W'(total) * P12_W'(DIV12_MUL);
    r12_raw = total - REM_W'({q12_q, 3'b000}) - REM_W'({q12_q, 2'b00});
    if (r12_raw >= REM_W'(12)) begin
      r12     = MONTH_W'(r12_raw - REM_W'(12));
      q12_fix = {1'b0, q12_q} + (Q12_W+1)'(1);
    end else begin
      r12     = MONTH_W'(r12_raw);
      q12_fix = {1'b0, q12_q};
    end
  end

  // leap year: divisible by 4 and (not by 25, or by 16)
  always_comb begin
    prod25  = P25_W'(year_q) * P25_W'(DIV25_MUL);
    r25_raw = year_q - (YEAR_BITS'({q25_q, 4'b0000}) + YEAR_BITS'({q25_q, 3'b000})
                        + YEAR_BITS'(q25_q));
    r25     = R25_W'(r25_raw);
    if (r25 >= R25_W'(25)) begin
      r25 = r25 - R25_W'(25);
    end
    leap_nx = (year_q[1:0] == 2'b00) && ((r25 != '0) || (year_q[3:0] == 4'b0000));
  end

  always_comb begin
    if (ld_month_q == '0) begin
      load_month_fix = MONTH_JAN;
    end else if (ld_month_q > MONTH_DEC) begin
      load_month_fix = MONTH_DEC;
    end else begin
      load_month_fix = ld_month_q;
    end
  end

  always_comb begin
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    leap_d      = leap_q;
    rem_d       = rem_q;
    q12_d       = q12_q;
    q25_d       = q25_q;
    ld_year_d   = ld_year_q;
    ld_month_d  = ld_month_q;
    ld_day_d    = ld_day_q;
    amt_d       = amt_q;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    case (cmd_i.op)
      DP_CAPTURE: begin
        ld_year_d  = load_year_i;
        ld_month_d = load_month_i;
        ld_day_d   = load_day_i;
        amt_d      = amount_i;
      end
      DP_LOAD: begin
        year_d  = sat_year({1'b0, ld_year_q});
        month_d = load_month_fix;
        day_d   = (ld_day_q == '0) ? DAY_W'(1) : ld_day_q;
      end
      DP_ADD_YEARS: begin
        year_d = sat_year({1'b0, year_q} + (YEAR_BITS+1)'(amt_q));
      end
      DP_MON_MUL: begin
        q12_d = Q12_W'(prod12 >> DIV12_SHIFT);
      end
      DP_MON_APPLY: begin
        year_d  = sat_year({1'b0, year_q} + (YEAR_BITS+1)'(q12_fix));
        month_d = r12 + MONTH_W'(1);
      end
      DP_DAYS_FIRST: begin
        if (first_fits) begin
          day_d = day_q + DAY_W'(amt_q);
        end else begin
          rem_d   = rem_first;
          month_d = month_nx;
          year_d  = year_nx;
          day_d   = DAY_W'(1);
        end
      end
      DP_DAYS_WALK: begin
        if (walk_stop) begin
          day_d = DAY_W'(rem_q) + DAY_W'(1);
        end else begin
          rem_d   = rem_q - REM_W'(md);
          month_d = month_nx;
          year_d  = year_nx;
        end
      end
      DP_LEAP_MUL: begin
        q25_d = Q25_W'(prod25 >> DIV25_SHIFT);
      end
      DP_LEAP_CHK: begin
        leap_d = leap_nx;
      end
      DP_OUT_LOAD: begin
        out_year_d  = year_q;
        out_month_d = month_q;
        out_day_d   = day_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= sat_year((YEAR_BITS+1)'(RESET_YEAR));
      month_q <= RESET_MONTH;
      day_q   <= RESET_DAY;
      leap_q  <= 1'b1;
    end else begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      leap_q  <= leap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    q12_q       <= q12_d;
    q25_q       <= q25_d;
    ld_year_q   <= ld_year_d;
    ld_month_q  <= ld_month_d;
    ld_day_q    <= ld_day_d;
    amt_q       <= amt_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
  end

  assign sts_o.first_fits = first_fits;
  assign sts_o.walk_stop  = walk_stop;
  assign sts_o.month_wrap = month_wrap;

  assign cur_year_o  = out_year_q;
  assign cur_month_o = out_month_q;
  assign cur_day_o   = out_day_q;

endmodule

/* src/cda_ctrl.sv */
// controller: sequences each request through the datapath and owns the handshakes
module cda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cda_pkg::cda_cmd_t cmd_o,
  input  cda_pkg::cda_sts_t sts_i
);
  import cda_pkg::*;

  state_e state_q, state_d;
  logic   ret_walk_q, ret_walk_d;
  logic   out_valid_q, out_valid_d;
  req_e   req;

  assign req = req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_walk_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_walk_q  <= ret_walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_walk_d  = ret_walk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = DP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_CAPTURE;
          case (req)
            REQ_LOAD:       state_d = ST_LOAD;
            REQ_ADD_DAYS:   state_d = ST_DAYS_FIRST;
            REQ_ADD_MONTHS: state_d = ST_MON_MUL;
            REQ_ADD_YEARS:  state_d = ST_ADD_YEARS;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.op   = DP_LOAD;
        ret_walk_d = 1'b0;
        state_d    = ST_LEAP_MUL;
      end
      ST_ADD_YEARS: begin
        cmd_o.op   = DP_ADD_YEARS;
        ret_walk_d = 1'b0;
        state_d    = ST_LEAP_MUL;
      end
      ST_MON_MUL: begin
        cmd_o.op = DP_MON_MUL;
        state_d  = ST_MON_APPLY;
      end
      ST_MON_APPLY: begin
        cmd_o.op   = DP_MON_APPLY;
        ret_walk_d = 1'b0;
        state_d    = ST_LEAP_MUL;
      end
      ST_DAYS_FIRST: begin
        cmd_o.op = DP_DAYS_FIRST;
        if (sts_i.first_fits) begin
          state_d = ST_FINISH;
        end else if (sts_i.month_wrap) begin
          ret_walk_d = 1'b1;
          state_d    = ST_LEAP_MUL;
        end else begin
          state_d = ST_DAYS_WALK;
        end
      end
      ST_DAYS_WALK: begin
        cmd_o.op = DP_DAYS_WALK;
        if (sts_i.walk_stop) begin
          state_d = ST_FINISH;
        end else if (sts_i.month_wrap) begin
          // new year: leap flag must be refreshed before february comes round
          ret_walk_d = 1'b1;
          state_d    = ST_LEAP_MUL;
        end
      end
      ST_LEAP_MUL: begin
        cmd_o.op = DP_LEAP_MUL;
        state_d  = ST_LEAP_CHK;
      end
      ST_LEAP_CHK: begin
        cmd_o.op = DP_LEAP_CHK;
        state_d  = ret_walk_q ? ST_DAYS_WALK : ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_OUT_LOAD;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/cda_checker.sv */
// port-level checker for the calendar date adder, bound to the top level
`include "calendar_date_adder_macros.svh"

module cda_checker #(
  parameter int YEAR_BITS = 14
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [YEAR_BITS-1:0]        cur_year_o,
  input logic [cda_pkg::MONTH_W-1:0] cur_month_o,
  input logic [cda_pkg::DAY_W-1:0]   cur_day_o
);
  import cda_pkg::*;

  localparam int unsigned YEAR_FULL = (1 << YEAR_BITS) - 1;
  localparam int unsigned YEAR_LIM  = (YEAR_FULL < YEAR_CAP) ? YEAR_FULL : YEAR_CAP;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = YEAR_BITS'(YEAR_LIM);

  // a taken transaction is worked on alone
  `CDA_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  `CDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(cur_year_o) && $stable(cur_month_o) && $stable(cur_day_o), "stalled result changed")

  `CDA_ASSERT_NOW(a_date_range, clk_i, rst_ni, out_valid_o, cur_month_o >= MONTH_JAN && cur_month_o <= MONTH_DEC && cur_day_o != '0, "month or day out of range")

  `CDA_ASSERT_NOW(a_year_limit, clk_i, rst_ni, out_valid_o, cur_year_o <= YEAR_MAX, "year above limit")

endmodule

bind calendar_date_adder cda_checker #(
  .YEAR_BITS (YEAR_BITS)
) u_cda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cur_year_o  (cur_year_o),
  .cur_month_o (cur_month_o),
  .cur_day_o   (cur_day_o)
);
